/* rtl/kdbp_pkg.sv */
package kdbp_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned ID_BITS   = 16;
  localparam int unsigned DIST_BITS = 24;

  localparam int unsigned BND_BITS  = DIST_BITS + 2;
  localparam int unsigned IDX_BITS  = $clog2(CAPACITY);
  localparam int unsigned CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int unsigned K_BITS    = 7;

  localparam int unsigned ADDR_BITS    = 4;
  localparam int unsigned REG_IDX_BITS = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_NEIGHBORS      = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_BOUND   = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_PARTIAL = 2'd2;

  localparam logic [K_BITS-1:0] NEIGHBORS_RESET = 7'd3;

  typedef struct packed {
    logic [ID_BITS-1:0]         id;
    logic signed [BND_BITS-1:0] lo;
    logic [BND_BITS-1:0]        up;
  } entry_t;

  localparam int unsigned ENTRY_BITS = $bits(entry_t);

endpackage

/* rtl/kdbp_if.sv */
interface kdbp_row_if;
  logic                           valid;
  logic                           ready;
  logic [kdbp_pkg::ID_BITS-1:0]   cand_id;
  logic [kdbp_pkg::DIST_BITS-1:0] measured_distance;
  logic [kdbp_pkg::DIST_BITS-1:0] cand_bound;
  logic [kdbp_pkg::DIST_BITS-1:0] cand_partial_bound;
  logic                           set_end;

  modport source (
    output valid, cand_id, measured_distance, cand_bound, cand_partial_bound, set_end,
    input  ready
  );
  modport sink (
    input  valid, cand_id, measured_distance, cand_bound, cand_partial_bound, set_end,
    output ready
  );
endinterface

interface kdbp_surv_if;
  logic                         valid;
  logic                         ready;
  logic [kdbp_pkg::ID_BITS-1:0] survivor_id;
  logic                         last_survivor;
  logic                         dropped_rows;

  modport source (
    output valid, survivor_id, last_survivor, dropped_rows,
    input  ready
  );
  modport sink (
    input  valid, survivor_id, last_survivor, dropped_rows,
    output ready
  );
endinterface

/* rtl/kdbp_ram.sv */
module kdbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/knn_distance_bound_prune.sv */
// Row without set end: the id search walks the entry memory one read and one compare
// per entry, then the entry is written and the block returns to ready.
// Row with set end: further bit-by-bit k-th selection over DIST_BITS+2 bits, then
// emission and a closing state, all on the single memory read port.
// Reset (rst_ni low, asynchronous) clears the count, the drop flag, the sequencer
// and restores register defaults; the entry memory needs no clearing pass.
module knn_distance_bound_prune (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  kdbp_row_if.sink                          in_i,
  kdbp_surv_if.source                       out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kdbp_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned IB = kdbp_pkg::ID_BITS;
  localparam int unsigned DB = kdbp_pkg::DIST_BITS;
  localparam int unsigned BB = kdbp_pkg::BND_BITS;
  localparam int unsigned XB = kdbp_pkg::IDX_BITS;
  localparam int unsigned CB = kdbp_pkg::CNT_BITS;
  localparam int unsigned KB = kdbp_pkg::K_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCHK,
    ST_WR,
    ST_PRD,
    ST_PCHK,
    ST_ERD,
    ST_ECHK,
    ST_FIN
  } state_e;

  // configuration
  logic [KB-1:0] k_q;
  logic [DB-1:0] tb_q;
  logic [DB-1:0] tpb_q;
  logic          cfg_we;
  logic [kdbp_pkg::REG_IDX_BITS-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[kdbp_pkg::REG_IDX_BITS+1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= kdbp_pkg::NEIGHBORS_RESET;
      tb_q  <= '0;
      tpb_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        kdbp_pkg::REG_NEIGHBORS:      k_q   <= pwdata[KB-1:0];
        kdbp_pkg::REG_TARGET_BOUND:   tb_q  <= pwdata[DB-1:0];
        kdbp_pkg::REG_TARGET_PARTIAL: tpb_q <= pwdata[DB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      kdbp_pkg::REG_NEIGHBORS:      prdata = 32'(k_q);
      kdbp_pkg::REG_TARGET_BOUND:   prdata = 32'(tb_q);
      kdbp_pkg::REG_TARGET_PARTIAL: prdata = 32'(tpb_q);
      default:                      prdata = '0;
    endcase
  end

  // sequencer state
  state_e               st_q;
  logic [CB-1:0]        cnt_q;
  logic                 ovf_q;
  logic [CB-1:0]        idx_q;
  logic                 found_q;
  logic [IB-1:0]        row_id_q;
  logic signed [BB-1:0] row_lo_q;
  logic [BB-1:0]        row_up_q;
  logic                 row_end_q;
  logic [KB-1:0]        krem_q;
  logic [CB-1:0]        c0_q;
  logic [BB-1:0]        prefix_q;
  logic [BB-1:0]        mask_q;
  logic [BB-1:0]        bitoh_q;
  logic                 held_v_q;
  logic [IB-1:0]        held_id_q;
  logic                 out_valid_q;
  logic [IB-1:0]        out_id_q;
  logic                 out_last_q;
  logic                 out_drop_q;

  // memory port
  logic                          ram_we;
  logic                          ram_re;
  logic [XB-1:0]                 ram_addr;
  logic [kdbp_pkg::ENTRY_BITS-1:0] ram_rdata;
  kdbp_pkg::entry_t              wr_entry;
  kdbp_pkg::entry_t              rd_entry;

  logic                 in_beat;
  logic                 out_free;
  logic signed [BB-1:0] lo_new;
  logic [BB-1:0]        up_new;
  logic                 last_ent;
  logic                 hit;
  logic [CB-1:0]        c_sum;
  logic                 keep;
  logic [KB-1:0]        k_eff;
  logic                 emit;

  assign in_beat  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (st_q == ST_IDLE);

  assign lo_new = $signed(BB'(in_i.measured_distance) - BB'(in_i.cand_partial_bound)
                          - BB'(tpb_q));
  assign up_new = BB'(in_i.measured_distance) + BB'(in_i.cand_bound) + BB'(tb_q);

  assign rd_entry = kdbp_pkg::entry_t'(ram_rdata);
  assign last_ent = (idx_q + CB'(1)) == cnt_q;
  assign hit      = (((rd_entry.up ^ prefix_q) & mask_q) == '0)
                    && ((rd_entry.up & bitoh_q) == '0);
  assign c_sum    = c0_q + CB'(hit);
  assign keep     = rd_entry.lo <= $signed({1'b0, prefix_q});
  assign k_eff    = (k_q == '0) ? KB'(1) : k_q;
  assign emit     = out_free && held_v_q &&
                    (((st_q == ST_ECHK) && keep) || (st_q == ST_FIN));

  assign ram_re   = (st_q == ST_SRD) || (st_q == ST_PRD) || (st_q == ST_ERD);
  assign ram_we   = (st_q == ST_WR) && (found_q || (cnt_q < CB'(kdbp_pkg::CAPACITY)));
  assign ram_addr = idx_q[XB-1:0];
  assign wr_entry = '{id: row_id_q, lo: row_lo_q, up: row_up_q};

  kdbp_ram #(
    .WIDTH (kdbp_pkg::ENTRY_BITS),
    .DEPTH (kdbp_pkg::CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      row_id_q    <= '0;
      row_lo_q    <= '0;
      row_up_q    <= '0;
      row_end_q   <= 1'b0;
      krem_q      <= '0;
      c0_q        <= '0;
      prefix_q    <= '0;
      mask_q      <= '0;
      bitoh_q     <= '0;
      held_v_q    <= 1'b0;
      held_id_q   <= '0;
      out_valid_q <= 1'b0;
      out_id_q    <= '0;
      out_last_q  <= 1'b0;
      out_drop_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && !emit) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (in_beat) begin
            row_id_q  <= in_i.cand_id;
            row_lo_q  <= lo_new;
            row_up_q  <= up_new;
            row_end_q <= in_i.set_end;
            idx_q     <= '0;
            found_q   <= 1'b0;
            st_q      <= (cnt_q == '0) ? ST_WR : ST_SRD;
          end
        end
        ST_SRD: st_q <= ST_SCHK;
        ST_SCHK: begin
          if (rd_entry.id == row_id_q) begin
            found_q <= 1'b1;
            st_q    <= ST_WR;
          end else if (last_ent) begin
            idx_q <= cnt_q;
            st_q  <= ST_WR;
          end else begin
            idx_q <= idx_q + CB'(1);
            st_q  <= ST_SRD;
          end
        end
        ST_WR: begin
          if (!found_q) begin
            if (cnt_q < CB'(kdbp_pkg::CAPACITY)) begin
              cnt_q <= cnt_q + CB'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
          idx_q    <= '0;
          krem_q   <= k_eff;
          c0_q     <= '0;
          prefix_q <= '0;
          mask_q   <= '0;
          bitoh_q  <= {1'b1, {(BB-1){1'b0}}};
          held_v_q <= 1'b0;
          st_q     <= row_end_q ? ST_PRD : ST_IDLE;
        end
        ST_PRD: st_q <= ST_PCHK;
        ST_PCHK: begin
          if (last_ent) begin
            // settle this bit of the threshold
            if (KB'(c_sum) < krem_q) begin
              prefix_q <= prefix_q | bitoh_q;
              krem_q   <= krem_q - KB'(c_sum);
            end
            mask_q  <= mask_q | bitoh_q;
            bitoh_q <= bitoh_q >> 1;
            c0_q    <= '0;
            idx_q   <= '0;
            st_q    <= bitoh_q[0] ? ST_ERD : ST_PRD;
          end else begin
            c0_q  <= c_sum;
            idx_q <= idx_q + CB'(1);
            st_q  <= ST_PRD;
          end
        end
        ST_ERD: st_q <= ST_ECHK;
        ST_ECHK: begin
          if (!(keep && held_v_q && !out_free)) begin
            if (keep) begin
              if (held_v_q) begin
                out_valid_q <= 1'b1;
                out_id_q    <= held_id_q;
                out_last_q  <= 1'b0;
                out_drop_q  <= ovf_q;
              end
              held_id_q <= rd_entry.id;
              held_v_q  <= 1'b1;
            end
            if (last_ent) begin
              st_q <= ST_FIN;
            end else begin
              idx_q <= idx_q + CB'(1);
              st_q  <= ST_ERD;
            end
          end
        end
        ST_FIN: begin
          if (!held_v_q || out_free) begin
            if (held_v_q) begin
              out_valid_q <= 1'b1;
              out_id_q    <= held_id_q;
              out_last_q  <= 1'b1;
              out_drop_q  <= ovf_q;
            end
            held_v_q <= 1'b0;
            cnt_q    <= '0;
            ovf_q    <= 1'b0;
            st_q     <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.survivor_id   = out_id_q;
  assign out_o.last_survivor = out_last_q;
  assign out_o.dropped_rows  = out_drop_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CB'(kdbp_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_port_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("memory read and write in one cycle");

  a_row_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WR) |-> (row_lo_q <= $signed({1'b0, row_up_q})))
    else $error("lower bound above upper bound");

  a_rank_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PRD || st_q == ST_PCHK) |-> (krem_q != '0))
    else $error("selection rank exhausted");

  a_fin_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FIN && (!held_v_q || out_free)) |=> (cnt_q == '0 && !ovf_q))
    else $error("store not emptied after set end");

endmodule

/* tb/kdbp_tb_pkg.sv */
`timescale 1ns / 1ps

package kdbp_tb_pkg;
  import kdbp_pkg::*;

  localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [ID_BITS-1:0]   cand_id;
    logic [DIST_BITS-1:0] measured_distance;
    logic [DIST_BITS-1:0] cand_bound;
    logic [DIST_BITS-1:0] cand_partial_bound;
    logic                 set_end;
  } cand_row_t;

  typedef struct packed {
    logic [ID_BITS-1:0] survivor_id;
    logic               last_survivor;
    logic               dropped_rows;
  } survivor_t;

  class survivor_tracker;
    logic [ID_BITS-1:0]   held_ids[$];
    longint               held_lower[$];
    longint               held_upper[$];
    bit                   rows_lost;
    logic [K_BITS-1:0]    k_reg;
    logic [DIST_BITS-1:0] query_bound;
    logic [DIST_BITS-1:0] query_partial;
    survivor_t            due_survivors[$];
    int unsigned          errors;
    int unsigned          rows_taken;
    int unsigned          sets_closed;
    int unsigned          lossy_sets;
    int unsigned          survivors_seen;

    function new();
      k_reg          = NEIGHBORS_RESET;
      query_bound    = '0;
      query_partial  = '0;
      rows_lost      = 1'b0;
      errors         = 0;
      rows_taken     = 0;
      sets_closed    = 0;
      lossy_sets     = 0;
      survivors_seen = 0;
    endfunction

    function void write_reg(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
      case (idx)
        REG_NEIGHBORS:      k_reg         = value[K_BITS-1:0];
        REG_TARGET_BOUND:   query_bound   = value[DIST_BITS-1:0];
        REG_TARGET_PARTIAL: query_partial = value[DIST_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [REG_IDX_BITS-1:0] idx);
      case (idx)
        REG_NEIGHBORS:      return 32'(k_reg);
        REG_TARGET_BOUND:   return 32'(query_bound);
        REG_TARGET_PARTIAL: return 32'(query_partial);
        default:            return '0;
      endcase
    endfunction

    function int unsigned pending();
      return due_survivors.size();
    endfunction

    function void take_row(cand_row_t row);
      longint      lower;
      longint      upper;
      longint      cut;
      longint      ranked[$];
      int          slot;
      int unsigned k;
      int unsigned first;
      survivor_t   s;
      lower = longint'(row.measured_distance) - longint'(row.cand_partial_bound)
              - longint'(query_partial);
      upper = longint'(row.measured_distance) + longint'(row.cand_bound)
              + longint'(query_bound);
      slot = -1;
      foreach (held_ids[i])
        if (held_ids[i] == row.cand_id) slot = i;
      rows_taken++;
      if (slot >= 0) begin
        held_lower[slot] = lower;
        held_upper[slot] = upper;
      end else if (held_ids.size() < CAPACITY) begin
        held_ids   = {held_ids, row.cand_id};
        held_lower = {held_lower, lower};
        held_upper = {held_upper, upper};
      end else begin
        rows_lost = 1'b1;
      end
      if (!row.set_end) return;
      k = (k_reg == '0) ? 1 : int'(k_reg);
      ranked = held_upper;
      ranked.sort();
      first = due_survivors.size();
      if (ranked.size() > 0) begin
        cut = (k <= ranked.size()) ? ranked[k-1] : ranked[ranked.size()-1];
        foreach (held_ids[i]) begin
          if (held_lower[i] <= cut) begin
            s.survivor_id   = held_ids[i];
            s.last_survivor = 1'b0;
            s.dropped_rows  = rows_lost;
            due_survivors   = {due_survivors, s};
          end
        end
        if (due_survivors.size() > first)
          due_survivors[due_survivors.size()-1].last_survivor = 1'b1;
      end
      sets_closed++;
      if (rows_lost) lossy_sets++;
      held_ids.delete();
      held_lower.delete();
      held_upper.delete();
      rows_lost = 1'b0;
    endfunction

    function void check_survivor(survivor_t got);
      survivor_t want;
      survivors_seen++;
      if (due_survivors.size() == 0) begin
        $error("survivor_id: expected none, got %h", got.survivor_id);
        errors++;
        return;
      end
      want = due_survivors.pop_front();
      if (got.survivor_id !== want.survivor_id) begin
        $error("survivor_id: expected %h, got %h", want.survivor_id, got.survivor_id);
        errors++;
      end
      if (got.last_survivor !== want.last_survivor) begin
        $error("last_survivor: expected %b, got %b", want.last_survivor, got.last_survivor);
        errors++;
      end
      if (got.dropped_rows !== want.dropped_rows) begin
        $error("dropped_rows: expected %b, got %b", want.dropped_rows, got.dropped_rows);
        errors++;
      end
    endfunction
  endclass

endpackage

/* tb/knn_distance_bound_prune_test.sv */
`timescale 1ns / 1ps

module knn_distance_bound_prune_test;
  import kdbp_pkg::*;
  import kdbp_tb_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 20000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned PHASE_ROWS    = 60;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  kdbp_row_if  row_if();
  kdbp_surv_if surv_if();

  survivor_tracker board = new();
  int unsigned     burst_left;
  int unsigned     idle_cycles;
  int unsigned     stall_left;
  int unsigned     flow_left;
  bit              free_flow;

  knn_distance_bound_prune dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (row_if),
    .out_o   (surv_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: long free-flowing stretches mixed with short and long stalls
  initial begin
    surv_if.ready = 1'b0;
    stall_left    = 0;
    flow_left     = 0;
    free_flow     = 1'b0;
    forever begin
      @(negedge clk_i);
      if (flow_left == 0 && stall_left == 0) begin
        free_flow  = ($urandom_range(0, 3) == 0);
        flow_left  = free_flow ? $urandom_range(100, 400) : $urandom_range(1, 12);
        stall_left = free_flow ? 0 :
                     (($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 4));
      end
      if (flow_left > 0) begin
        surv_if.ready = 1'b1;
        flow_left--;
      end else begin
        surv_if.ready = 1'b0;
        stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (surv_if.valid === 1'b1 && surv_if.ready === 1'b1)
      board.check_survivor(survivor_t'{surv_if.survivor_id, surv_if.last_survivor,
                                        surv_if.dropped_rows});
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((row_if.valid && row_if.ready) || (surv_if.valid && surv_if.ready) ||
          (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: %0d cycles without a beat", IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_row(input cand_row_t row);
    if (burst_left == 0) begin
      row_if.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    row_if.valid              = 1'b1;
    row_if.cand_id            = row.cand_id;
    row_if.measured_distance  = row.measured_distance;
    row_if.cand_bound         = row.cand_bound;
    row_if.cand_partial_bound = row.cand_partial_bound;
    row_if.set_end            = row.set_end;
    do @(posedge clk_i); while (row_if.ready !== 1'b1);
    board.take_row(row);
    burst_left--;
    @(negedge clk_i);
  endtask

  // hold rows back until every survivor has arrived, then let the block settle
  task automatic drain();
    row_if.valid = 1'b0;
    burst_left   = 0;
    while (board.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_BITS'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    board.write_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_check(input logic [REG_IDX_BITS-1:0] idx);
    logic [31:0] seen;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_BITS'({idx, 2'b00});
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    seen = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (seen !== board.reg_value(idx)) begin
      $error("register %0d: expected %h, got %h", idx, board.reg_value(idx), seen);
      board.errors++;
    end
  endtask

  task automatic set_config(input int unsigned k, input logic [DIST_BITS-1:0] bound,
                            input logic [DIST_BITS-1:0] partial);
    apb_write(REG_NEIGHBORS, {25'($urandom), 7'(k)});
    apb_write(REG_TARGET_BOUND, {8'($urandom), bound});
    apb_write(REG_TARGET_PARTIAL, {8'($urandom), partial});
    apb_check(REG_NEIGHBORS);
    apb_check(REG_TARGET_BOUND);
    apb_check(REG_TARGET_PARTIAL);
  endtask

  function automatic logic [DIST_BITS-1:0] pick_span(input bit narrow);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return DIST_BITS'($urandom);
      default: return narrow ? DIST_BITS'($urandom_range(0, 'h3FF))
                             : DIST_BITS'($urandom_range(0, 'hFFFF));
    endcase
  endfunction

  function automatic cand_row_t make_row(input logic [ID_BITS-1:0] id, input bit last);
    cand_row_t row;
    row.cand_id            = id;
    row.measured_distance  = pick_span(1'b0);
    row.cand_bound         = pick_span(1'b1);
    row.cand_partial_bound = pick_span(1'b1);
    row.set_end            = last;
    return row;
  endfunction

  task automatic random_set();
    int unsigned        rows;
    bit                 wide;
    logic [ID_BITS-1:0] base;
    rows = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    wide = ($urandom_range(0, 3) == 0);
    base = ID_BITS'($urandom);
    for (int unsigned r = 0; r < rows; r++)
      send_row(make_row(wide ? ID_BITS'($urandom) : base + ID_BITS'($urandom_range(0, rows)),
                        r == rows - 1));
  endtask

  task automatic fill_past_capacity(input bit end_on_new);
    logic [ID_BITS-1:0] base;
    logic [ID_BITS-1:0] id;
    int unsigned        extra;
    base  = ID_BITS'($urandom);
    extra = $urandom_range(2, 10);
    for (int unsigned r = 0; r < CAPACITY; r++)
      send_row(make_row(base + ID_BITS'(r), 1'b0));
    for (int unsigned r = 0; r < extra; r++) begin
      if (r == extra - 1)
        id = end_on_new ? base + ID_BITS'(CAPACITY + r)
                        : base + ID_BITS'($urandom_range(0, CAPACITY - 1));
      else
        id = $urandom_range(0, 1) ? base + ID_BITS'(CAPACITY + r)
                                  : base + ID_BITS'($urandom_range(0, CAPACITY - 1));
      send_row(make_row(id, r == extra - 1));
    end
  endtask

  initial begin
    int unsigned phase_start;
    rst_ni                    = 1'b0;
    psel                      = 1'b0;
    penable                   = 1'b0;
    pwrite                    = 1'b0;
    paddr                     = '0;
    pwdata                    = '0;
    row_if.valid              = 1'b0;
    row_if.cand_id            = '0;
    row_if.measured_distance  = '0;
    row_if.cand_bound         = '0;
    row_if.cand_partial_bound = '0;
    row_if.set_end            = 1'b0;
    burst_left                = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    apb_check(REG_NEIGHBORS);
    apb_check(REG_TARGET_BOUND);
    apb_check(REG_TARGET_PARTIAL);

    // single all-zero row, fewer entries than k
    send_row(cand_row_t'{16'h0000, 24'h000000, 24'h000000, 24'h000000, 1'b1});
    // extremes, overwrite of a held id, negative lower bound, one pruned entry
    send_row(cand_row_t'{16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0});
    send_row(cand_row_t'{16'h0001, 24'h000100, 24'h000000, 24'h000000, 1'b0});
    send_row(cand_row_t'{16'hFFFF, 24'h000010, 24'h000000, 24'h000020, 1'b0});
    send_row(cand_row_t'{16'h0002, 24'hFFFFFF, 24'h000000, 24'h000000, 1'b0});
    send_row(cand_row_t'{16'h0003, 24'h000200, 24'h000000, 24'h000000, 1'b1});
    // tied upper bounds at the threshold, lower bound equal to it
    send_row(cand_row_t'{16'h0010, 24'h000300, 24'h000000, 24'h000000, 1'b0});
    send_row(cand_row_t'{16'h0011, 24'h000300, 24'h000000, 24'h000000, 1'b0});
    send_row(cand_row_t'{16'h0012, 24'h000300, 24'h000000, 24'h000000, 1'b0});
    send_row(cand_row_t'{16'h0013, 24'h000301, 24'h000000, 24'h000001, 1'b0});
    send_row(cand_row_t'{16'h0014, 24'h000400, 24'h000000, 24'h000000, 1'b1});
    // closing row repeats a held id
    send_row(cand_row_t'{16'h0020, 24'h001000, 24'h000000, 24'h000000, 1'b0});
    send_row(cand_row_t'{16'h0020, 24'h000800, 24'h000000, 24'h000000, 1'b1});

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: set_config(0, '1, '1);
        1: set_config(1, '0, '0);
        2: set_config(64, DIST_BITS'($urandom), DIST_BITS'($urandom));
        3: begin
          apb_write(REG_SPARE, 32'($urandom));
          set_config(127, DIST_BITS'($urandom_range(0, 'hFFF)),
                     DIST_BITS'($urandom_range(0, 'hFFF)));
        end
        4: set_config($urandom_range(2, 8), DIST_BITS'($urandom), '0);
        default: set_config($urandom_range(1, 64), '0, DIST_BITS'($urandom));
      endcase
      if (phase == 1) fill_past_capacity(1'b1);
      if (phase == 4) fill_past_capacity(1'b0);
      phase_start = board.rows_taken;
      while (board.rows_taken - phase_start < PHASE_ROWS) random_set();
    end
    drain();

    $display("Loaded %0d rows in %0d sets (%0d past capacity), checked %0d survivors.",
             board.rows_taken, board.sets_closed, board.lossy_sets, board.survivors_seen);
    $display("k ran through 0, 1, 64 and 127 with target bounds at zero, full scale and random.");
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/kdbp_pkg.sv
rtl/kdbp_if.sv
rtl/kdbp_ram.sv
rtl/knn_distance_bound_prune.sv
tb/kdbp_tb_pkg.sv
tb/knn_distance_bound_prune_test.sv
